@@ hw/rtl/rcfi_pkg.sv @@
// Shared constants, codes and the CORDIC arctangent table for the ray/cell face block.
`timescale 1ns / 1ps
package rcfi_pkg;

  localparam int ANGLE_IN_W        = 16;
  localparam int DEPTH_W           = 32;
  localparam int DIST_W            = 32;
  localparam int WEIGHT_W          = 17;
  localparam int CORDIC_W          = 32;
  localparam int IN_DATA_W         = 96;
  localparam int OUT_DATA_W        = 112;
  localparam int OUT_USER_W        = 2;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GAIN_Q30 = 652032874;
  localparam logic [DEPTH_W-1:0]  HALF_WIDTH_RST = 32'h0001_0000;
  localparam logic [WEIGHT_W-1:0] ONE_Q16        = 17'h1_0000;
  localparam logic [20:0]         F_LIMIT        = 21'h10_0000;

  localparam logic [1:0] FACE_Z = 2'd0;
  localparam logic [1:0] FACE_Y = 2'd1;
  localparam logic [1:0] FACE_X = 2'd2;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/rcfi_cordic.sv @@
// Pipelined CORDIC sine/cosine of a turn-fraction angle, one rotation per stage.
`timescale 1ns / 1ps
module rcfi_cordic #(
  parameter int ANGLE_BITS = rcfi_pkg::ANGLE_BITS_DEF,
  parameter int STAGES     = rcfi_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [rcfi_pkg::ANGLE_IN_W-1:0]      angle_i,
  output logic signed [rcfi_pkg::CORDIC_W-1:0] cos_o,
  output logic signed [rcfi_pkg::CORDIC_W-1:0] sin_o
);
  import rcfi_pkg::*;

  localparam int ZW = 33;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [31:0] phase;
  logic [31:0] phase_rnd;
  logic [1:0]  quad0;
  logic [31:0] resid;

  logic signed [CORDIC_W-1:0] x_r   [STAGES];
  logic signed [CORDIC_W-1:0] y_r   [STAGES];
  logic signed [ZW-1:0]       z_r   [STAGES];
  logic [1:0]                 q_r   [STAGES];
  logic signed [CORDIC_W-1:0] x_nxt [STAGES];
  logic signed [CORDIC_W-1:0] y_nxt [STAGES];
  logic signed [ZW-1:0]       z_nxt [STAGES];
  logic [1:0]                 q_nxt [STAGES];

  // remove the nearest quarter turn
  assign phase     = (32'(angle_i) & AMASK) << (32 - ANGLE_BITS);
  assign phase_rnd = phase + 32'h4000_0000;
  assign quad0     = phase_rnd[31:30];
  assign resid     = phase - {quad0, 30'b0};

  always_comb begin : rot_blk
    logic signed [CORDIC_W-1:0] xp;
    logic signed [CORDIC_W-1:0] yp;
    logic signed [ZW-1:0]       zp;
    logic [1:0]                 qp;
    logic [ZW-1:0]              at;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        xp = CORDIC_W'(GAIN_Q30);
        yp = '0;
        zp = {resid[31], resid};
        qp = quad0;
      end else begin
        xp = x_r[s-1];
        yp = y_r[s-1];
        zp = z_r[s-1];
        qp = q_r[s-1];
      end
      at = {1'b0, atan_turn(5'(s))};
      if (!zp[ZW-1]) begin
        x_nxt[s] = xp - (yp >>> s);
        y_nxt[s] = yp + (xp >>> s);
        z_nxt[s] = zp - at;
      end else begin
        x_nxt[s] = xp + (yp >>> s);
        y_nxt[s] = yp - (xp >>> s);
        z_nxt[s] = zp + at;
      end
      q_nxt[s] = qp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        x_r[s] <= x_nxt[s];
        y_r[s] <= y_nxt[s];
        z_r[s] <= z_nxt[s];
        q_r[s] <= q_nxt[s];
      end
    end
  end

  // put the quarter turn back
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (q_r[STAGES-1])
        QUAD_0: begin
          cos_o <= x_r[STAGES-1];
          sin_o <= y_r[STAGES-1];
        end
        QUAD_1: begin
          cos_o <= -y_r[STAGES-1];
          sin_o <= x_r[STAGES-1];
        end
        QUAD_2: begin
          cos_o <= -x_r[STAGES-1];
          sin_o <= -y_r[STAGES-1];
        end
        QUAD_3: begin
          cos_o <= y_r[STAGES-1];
          sin_o <= -x_r[STAGES-1];
        end
        default: begin
          cos_o <= x_r[STAGES-1];
          sin_o <= y_r[STAGES-1];
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/rcfi_udiv.sv @@
// Pipelined restoring unsigned divider, a few quotient bits per stage.
`timescale 1ns / 1ps
module rcfi_udiv #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 32,
  parameter int STEP  = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);
  import rcfi_pkg::*;

  localparam int NST = (Q_W + STEP - 1) / STEP;

  logic [DEN_W-1:0] rem_r   [NST];
  logic [Q_W-1:0]   num_r   [NST];
  logic [Q_W-1:0]   quo_r   [NST];
  logic [DEN_W-1:0] den_r   [NST];
  logic [DEN_W-1:0] rem_nxt [NST];
  logic [Q_W-1:0]   num_nxt [NST];
  logic [Q_W-1:0]   quo_nxt [NST];
  logic [DEN_W-1:0] den_nxt [NST];

  always_comb begin : step_blk
    logic [DEN_W-1:0] rv;
    logic [Q_W-1:0]   nv;
    logic [Q_W-1:0]   qv;
    logic [DEN_W-1:0] dv;
    logic [DEN_W:0]   r2;
    for (int s = 0; s < NST; s++) begin
      if (s == 0) begin
        rv = rem_i;
        nv = num_i;
        qv = '0;
        dv = den_i;
      end else begin
        rv = rem_r[s-1];
        nv = num_r[s-1];
        qv = quo_r[s-1];
        dv = den_r[s-1];
      end
      for (int k = 0; k < STEP; k++) begin
        if (s * STEP + k < Q_W) begin
          r2 = {rv, nv[Q_W-1]};
          nv = nv << 1;
          if (r2 >= {1'b0, dv}) begin
            r2 = r2 - {1'b0, dv};
            qv = {qv[Q_W-2:0], 1'b1};
          end else begin
            qv = {qv[Q_W-2:0], 1'b0};
          end
          rv = r2[DEN_W-1:0];
        end
      end
      rem_nxt[s] = rv;
      num_nxt[s] = nv;
      quo_nxt[s] = qv;
      den_nxt[s] = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign quo_o = quo_r[NST-1];

endmodule

@@ hw/rtl/ray_cell_face_intersection.sv @@
// Ray / cell face intersection: exit face, path distance and bilinear vertex weights.
// Pipeline: the CORDIC rotation pipeline, the 8-stage time divider and the 11-stage
// face coordinate dividers. Throughput: one item per cycle; every stage advances
// together when the output register is empty or taken. Reset (rst_n low, synchronous)
// empties the pipeline and sets half_cell_width to 1.0.
`timescale 1ns / 1ps
module ray_cell_face_intersection #(
  parameter int ANGLE_BITS    = rcfi_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rcfi_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // polar_angle, azimuth_angle, depth_below, depth_above
  input  logic [rcfi_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // path_distance, sign_x, sign_y, sign_z, weight_0, weight_1, weight_2,
  // weight_3, weight_clamped, width_invalid, zero pad
  output logic [rcfi_pkg::OUT_DATA_W-1:0]   out_tdata,
  // hit_face
  output logic [rcfi_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [rcfi_pkg::DEPTH_W-1:0]      cfg_wr_data
);
  import rcfi_pkg::*;

  localparam int T_STEP = 4;
  localparam int T_ST   = (DIST_W + T_STEP - 1) / T_STEP;
  localparam int C_QW   = 21;
  localparam int C_DW   = DEPTH_W + 14;
  localparam int C_STEP = 2;
  localparam int C_ST   = (C_QW + C_STEP - 1) / C_STEP;
  localparam int FR_LAT = CORDIC_STAGES + 1;
  localparam int LAT    = FR_LAT + 4 + T_ST + 2 + C_ST + 3;

  typedef struct packed {
    logic [DEPTH_W-1:0] zd;
    logic [DEPTH_W-1:0] zt;
    logic               winv;
  } front_t;

  typedef struct packed {
    logic [1:0]         face;
    logic               sx;
    logic               sy;
    logic               sz;
    logic               winv;
    logic               sat_t;
    logic [31:0]        ca;
    logic [DEPTH_W-1:0] wa;
    logic               pa;
    logic [31:0]        cb;
    logic [DEPTH_W-1:0] wb;
    logic               pb;
  } mid_t;

  typedef struct packed {
    logic [DIST_W-1:0] t;
    logic [1:0]        face;
    logic              sx;
    logic              sy;
    logic              sz;
    logic              winv;
  } tail_t;

  typedef struct packed {
    tail_t tl;
    logic  pa;
    logic  pb;
    logic  za;
    logic  zb;
    logic  sa;
    logic  sb;
  } back_t;

  function automatic logic [31:0] mag64(input logic signed [63:0] v);
    return v[63] ? 32'(-v) : 32'(v);
  endfunction

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic [DEPTH_W-1:0] half_width_r;

  // ---------------- input and CORDIC ----------------
  logic [ANGLE_IN_W-1:0] polar_angle, azimuth_angle;
  logic [DEPTH_W-1:0]    depth_below, depth_above;
  logic signed [CORDIC_W-1:0] ct, st, cc, sc;
  front_t fr_r [FR_LAT];
  front_t fr_in;

  assign en            = !vld_r[LAT-1] || out_tready;
  assign in_tready     = en;
  assign out_tvalid    = vld_r[LAT-1];
  assign polar_angle   = in_tdata[15:0];
  assign azimuth_angle = in_tdata[31:16];
  assign depth_below   = in_tdata[63:32];
  assign depth_above   = in_tdata[95:64];

  always_comb begin
    fr_in.zd   = depth_below;
    fr_in.zt   = depth_above;
    fr_in.winv = (half_width_r == '0) || (depth_below == '0) || (depth_above == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
    end else if (cfg_wr_en) begin
      half_width_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  rcfi_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_cordic_pol (
    .clk(clk), .en(en), .angle_i(polar_angle), .cos_o(ct), .sin_o(st)
  );

  rcfi_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_cordic_azi (
    .clk(clk), .en(en), .angle_i(azimuth_angle), .cos_o(cc), .sin_o(sc)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r[0] <= fr_in;
      for (int i = 1; i < FR_LAT; i++) fr_r[i] <= fr_r[i-1];
    end
  end

  // ---------------- direction components ----------------
  logic signed [63:0]      prod_x_r, prod_y_r;
  logic signed [CORDIC_W-1:0] m1_ct_r;
  front_t                  m1_fr_r;
  logic signed [63:0]      vx, vy;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= st * cc;
      prod_y_r <= st * sc;
      m1_ct_r  <= ct;
      m1_fr_r  <= fr_r[FR_LAT-1];
    end
  end

  assign vx = (prod_x_r + 64'sd536870912) >>> 30;
  assign vy = (prod_y_r + 64'sd536870912) >>> 30;

  logic [31:0]        ax_r, ay_r, az_r;
  logic               px_r, py_r, pz_r, m2_winv_r;
  logic [DEPTH_W-1:0] wz_r;

  // component d = -v, so positive means v negative
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= mag64(vx);
      ay_r      <= mag64(vy);
      az_r      <= mag64(64'(m1_ct_r));
      px_r      <= vx[63];
      py_r      <= vy[63];
      pz_r      <= m1_ct_r[CORDIC_W-1];
      wz_r      <= m1_ct_r[CORDIC_W-1] ? m1_fr_r.zt : m1_fr_r.zd;
      m2_winv_r <= m1_fr_r.winv;
    end
  end

  // ---------------- face choice ----------------
  logic [63:0]        pzx_r, pzy_r, plz_r;
  logic [31:0]        c1_ax_r, c1_ay_r, c1_az_r;
  logic               c1_px_r, c1_py_r, c1_pz_r, c1_winv_r;
  logic [DEPTH_W-1:0] c1_wz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pzx_r     <= 64'(wz_r) * 64'(ax_r);
      pzy_r     <= 64'(wz_r) * 64'(ay_r);
      plz_r     <= 64'(half_width_r) * 64'(az_r);
      c1_ax_r   <= ax_r;
      c1_ay_r   <= ay_r;
      c1_az_r   <= az_r;
      c1_px_r   <= px_r;
      c1_py_r   <= py_r;
      c1_pz_r   <= pz_r;
      c1_wz_r   <= wz_r;
      c1_winv_r <= m2_winv_r;
    end
  end

  logic z_le_x, z_le_y, y_le_x, y_le_z;
  mid_t c2_nxt;
  logic [DEPTH_W-1:0] tw_nxt;
  logic [31:0]        tc_nxt;

  // a zero component is an infinite time: loses to anything, ties with infinity
  always_comb begin
    z_le_x = (c1_az_r == '0) ? (c1_ax_r == '0) : ((c1_ax_r == '0) || (pzx_r <= plz_r));
    z_le_y = (c1_az_r == '0) ? (c1_ay_r == '0) : ((c1_ay_r == '0) || (pzy_r <= plz_r));
    y_le_x = (c1_ay_r == '0) ? (c1_ax_r == '0) :
             ((c1_ax_r == '0) || (half_width_r == '0) || (c1_ax_r <= c1_ay_r));
    y_le_z = (c1_ay_r == '0) ? (c1_az_r == '0) : ((c1_az_r == '0) || (plz_r <= pzy_r));

    c2_nxt.sx   = c1_px_r;
    c2_nxt.sy   = c1_py_r;
    c2_nxt.sz   = c1_pz_r;
    c2_nxt.winv = c1_winv_r;
    priority if (z_le_x && z_le_y) begin
      c2_nxt.face = FACE_Z;
      tw_nxt      = c1_wz_r;
      tc_nxt      = c1_az_r;
      c2_nxt.ca   = c1_ax_r;
      c2_nxt.wa   = half_width_r;
      c2_nxt.pa   = c1_px_r;
      c2_nxt.cb   = c1_ay_r;
      c2_nxt.wb   = half_width_r;
      c2_nxt.pb   = c1_py_r;
    end else if (y_le_x && y_le_z) begin
      c2_nxt.face = FACE_Y;
      tw_nxt      = half_width_r;
      tc_nxt      = c1_ay_r;
      c2_nxt.ca   = c1_ax_r;
      c2_nxt.wa   = half_width_r;
      c2_nxt.pa   = c1_px_r;
      c2_nxt.cb   = c1_az_r;
      c2_nxt.wb   = c1_wz_r;
      c2_nxt.pb   = c1_pz_r;
    end else begin
      c2_nxt.face = FACE_X;
      tw_nxt      = half_width_r;
      tc_nxt      = c1_ax_r;
      c2_nxt.ca   = c1_ay_r;
      c2_nxt.wa   = half_width_r;
      c2_nxt.pa   = c1_py_r;
      c2_nxt.cb   = c1_az_r;
      c2_nxt.wb   = c1_wz_r;
      c2_nxt.pb   = c1_pz_r;
    end
    // quotient overflows 32 bits exactly when w >= 4c
    c2_nxt.sat_t = (tc_nxt == '0) || ({2'b0, tw_nxt} >= {tc_nxt, 2'b0});
  end

  mid_t               c2_r;
  logic [DEPTH_W-1:0] tw_r;
  logic [31:0]        tc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= c2_nxt;
      tw_r <= tw_nxt;
      tc_r <= tc_nxt;
    end
  end

  // ---------------- path distance ----------------
  logic [DIST_W-1:0] quo_t;
  mid_t              mid_d [T_ST];

  rcfi_udiv #(.DEN_W(32), .Q_W(DIST_W), .STEP(T_STEP)) u_div_time (
    .clk(clk), .en(en),
    .rem_i({2'b0, tw_r[DEPTH_W-1:2]}),
    .num_i({tw_r[1:0], 30'b0}),
    .den_i(tc_r),
    .quo_o(quo_t)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mid_d[0] <= c2_r;
      for (int i = 1; i < T_ST; i++) mid_d[i] <= mid_d[i-1];
    end
  end

  mid_t               md;
  logic [DIST_W-1:0]  t_sel;
  tail_t              p1_tl_r;
  logic [63:0]        prod_a_r, prod_b_r;
  logic [DEPTH_W-1:0] p1_wa_r, p1_wb_r;
  logic               p1_pa_r, p1_pb_r;

  assign md    = mid_d[T_ST-1];
  assign t_sel = md.sat_t ? '1 : quo_t;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tl_r.t    <= t_sel;
      p1_tl_r.face <= md.face;
      p1_tl_r.sx   <= md.sx;
      p1_tl_r.sy   <= md.sy;
      p1_tl_r.sz   <= md.sz;
      p1_tl_r.winv <= md.winv;
      prod_a_r     <= 64'(t_sel) * 64'(md.ca);
      prod_b_r     <= 64'(t_sel) * 64'(md.cb);
      p1_wa_r      <= md.wa;
      p1_wb_r      <= md.wb;
      p1_pa_r      <= md.pa;
      p1_pb_r      <= md.pb;
    end
  end

  // ---------------- face coordinates ----------------
  logic [64:0]     num_a, num_b;
  logic [C_DW-1:0] den_a, den_b;
  logic [C_DW-1:0] rem_a_r, rem_b_r, den_a_r, den_b_r;
  logic [C_QW-1:0] low_a_r, low_b_r;
  back_t           p2_r;

  assign num_a = {1'b0, prod_a_r} + 65'({p1_wa_r, 13'b0});
  assign num_b = {1'b0, prod_b_r} + 65'({p1_wb_r, 13'b0});
  assign den_a = {p1_wa_r, 14'b0};
  assign den_b = {p1_wb_r, 14'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r <= {2'b0, num_a[64:C_QW]};
      rem_b_r <= {2'b0, num_b[64:C_QW]};
      low_a_r <= num_a[C_QW-1:0];
      low_b_r <= num_b[C_QW-1:0];
      den_a_r <= den_a;
      den_b_r <= den_b;
      p2_r.tl <= p1_tl_r;
      p2_r.pa <= p1_pa_r;
      p2_r.pb <= p1_pb_r;
      p2_r.za <= (p1_wa_r == '0);
      p2_r.zb <= (p1_wb_r == '0);
      // quotient of 2^21 or more: limited anyway
      p2_r.sa <= ({2'b0, num_a[64:C_QW]} >= den_a);
      p2_r.sb <= ({2'b0, num_b[64:C_QW]} >= den_b);
    end
  end

  logic [C_QW-1:0] quo_a, quo_b;
  back_t           back_d [C_ST];

  rcfi_udiv #(.DEN_W(C_DW), .Q_W(C_QW), .STEP(C_STEP)) u_div_coord_a (
    .clk(clk), .en(en), .rem_i(rem_a_r), .num_i(low_a_r), .den_i(den_a_r), .quo_o(quo_a)
  );

  rcfi_udiv #(.DEN_W(C_DW), .Q_W(C_QW), .STEP(C_STEP)) u_div_coord_b (
    .clk(clk), .en(en), .rem_i(rem_b_r), .num_i(low_b_r), .den_i(den_b_r), .quo_o(quo_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      back_d[0] <= p2_r;
      for (int i = 1; i < C_ST; i++) back_d[i] <= back_d[i-1];
    end
  end

  back_t              bk;
  logic [C_QW-1:0]    fa, fb;
  logic signed [21:0] ca_v, cb_v;

  assign bk = back_d[C_ST-1];

  always_comb begin
    fa = bk.za ? '0 : ((bk.sa || (quo_a > F_LIMIT)) ? F_LIMIT : quo_a);
    fb = bk.zb ? '0 : ((bk.sb || (quo_b > F_LIMIT)) ? F_LIMIT : quo_b);
    ca_v = bk.pa ? $signed({1'b0, fa}) : 22'sd65536 - $signed({1'b0, fa});
    cb_v = bk.pb ? $signed({1'b0, fb}) : 22'sd65536 - $signed({1'b0, fb});
  end

  logic signed [21:0] a_r, b_r, oma_r, omb_r;
  tail_t              a_tl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= ca_v;
      b_r    <= cb_v;
      oma_r  <= 22'sd65536 - ca_v;
      omb_r  <= 22'sd65536 - cb_v;
      a_tl_r <= bk.tl;
    end
  end

  // ---------------- weights ----------------
  logic signed [43:0] pw0_r, pw1_r, pw2_r, pw3_r;
  tail_t              w_tl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pw0_r  <= oma_r * omb_r;
      pw1_r  <= a_r * omb_r;
      pw2_r  <= a_r * b_r;
      pw3_r  <= oma_r * b_r;
      w_tl_r <= a_tl_r;
    end
  end

  logic signed [43:0]  rw [4];
  logic [WEIGHT_W-1:0] wq [4];
  logic [3:0]          wc;

  always_comb begin
    rw[0] = (pw0_r + 44'sd32768) >>> 16;
    rw[1] = (pw1_r + 44'sd32768) >>> 16;
    rw[2] = (pw2_r + 44'sd32768) >>> 16;
    rw[3] = (pw3_r + 44'sd32768) >>> 16;
    for (int i = 0; i < 4; i++) begin
      if (rw[i] < 0) begin
        wq[i] = '0;
        wc[i] = 1'b1;
      end else if (rw[i] > 44'sd65536) begin
        wq[i] = ONE_Q16;
        wc[i] = 1'b1;
      end else begin
        wq[i] = rw[i][WEIGHT_W-1:0];
        wc[i] = 1'b0;
      end
    end
  end

  tail_t               out_tl_r;
  logic [WEIGHT_W-1:0] out_w0_r, out_w1_r, out_w2_r, out_w3_r;
  logic                out_clamp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_tl_r    <= w_tl_r;
      out_w0_r    <= wq[0];
      out_w1_r    <= wq[1];
      out_w2_r    <= wq[2];
      out_w3_r    <= wq[3];
      out_clamp_r <= |wc;
    end
  end

  assign out_tdata = {7'b0, out_tl_r.winv, out_clamp_r, out_w3_r, out_w2_r, out_w1_r,
                      out_w0_r, out_tl_r.sz, out_tl_r.sy, out_tl_r.sx, out_tl_r.t};
  assign out_tuser = out_tl_r.face;

  // ---------------- checks ----------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_w0_r <= ONE_Q16) && (out_w1_r <= ONE_Q16) &&
                   (out_w2_r <= ONE_Q16) && (out_w3_r <= ONE_Q16))
    else $error("weight above one after clamping");

  a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tl_r.face != FACE_Z) |-> (out_tl_r.face == FACE_Y) ||
                                                (out_tl_r.face == FACE_X))
    else $error("bad hit face");

endmodule

@@ bench/tb_ray_cell_face_intersection.sv @@
// Self-checking bench for the ray / cell face intersection block.
`timescale 1ns / 1ps
module tb_ray_cell_face_intersection;
  import rcfi_pkg::*;

  typedef struct packed {
    logic [31:0] path_d;
    logic [1:0]  face;
    logic        sx, sy, sz;
    logic [16:0] w0, w1, w2, w3;
    logic        clamped, invalid;
  } face_hit_t;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [DEPTH_W-1:0] cfg_wr_data = '0;

  int src_idle = 0;
  int snk_idle = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  ray_cell_face_intersection uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  class face_scoreboard;
    face_hit_t pending[$];
    logic [31:0] half_w = 32'h0001_0000;
    int errors = 0;

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function void rotate(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] p, rr;
      logic [1:0] q;
      longint x, y, z, dx, dy;
      p = {ang, 16'h0};
      q = 2'((p + 32'h4000_0000) >> 30);
      rr = p - ({30'd0, q} << 30);
      z = longint'($signed(rr));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
        end
      end
      case (q)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function bit time_le(longint wa, longint ca, longint wb, longint cb);
      if (ca == 0) return cb == 0;
      if (cb == 0) return 1;
      return wa * cb <= wb * ca;
    endfunction

    function logic [31:0] time_to(longint w, longint c);
      longint t;
      if (c == 0) return 32'hFFFF_FFFF;
      t = (w << 30) / c;
      return t > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function longint face_coord(logic [31:0] t, longint c, longint w, bit pos);
      longint unsigned f, den;
      f = 0;
      if (w != 0) begin
        den = w << 14;
        f = (longint'(t) * c + (den >> 1)) / den;
        if (f > 1048576) f = 1048576;
      end
      return pos ? longint'(f) : 65536 - longint'(f);
    endfunction

    function logic [16:0] blend(longint a, longint b, ref bit clamped);
      longint r;
      r = floor_shr(a * b + 32768, 16);
      if (r < 0) begin clamped = 1; return 0; end
      if (r > 65536) begin clamped = 1; return ONE_Q16; end
      return r[16:0];
    endfunction

    function void note_item(logic [IN_DATA_W-1:0] d);
      longint ct, st, cc, sc, dx, dy, dz, ax, ay, az, wz, lw, zd, zt, a, b;
      bit clamped;
      face_hit_t e;
      clamped = 0;
      lw = half_w;
      zd = d[63:32];
      zt = d[95:64];
      rotate(d[15:0], ct, st);
      rotate(d[31:16], cc, sc);
      dx = -floor_shr(st * cc + (64'sd1 << 29), 30);
      dy = -floor_shr(st * sc + (64'sd1 << 29), 30);
      dz = -ct;
      e.sx = dx > 0; e.sy = dy > 0; e.sz = dz > 0;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      wz = e.sz ? zt : zd;
      if (time_le(wz, az, lw, ax) && time_le(wz, az, lw, ay)) begin
        e.face = FACE_Z;
        e.path_d = time_to(wz, az);
        a = face_coord(e.path_d, ax, lw, e.sx);
        b = face_coord(e.path_d, ay, lw, e.sy);
      end else if (time_le(lw, ay, lw, ax) && time_le(lw, ay, wz, az)) begin
        e.face = FACE_Y;
        e.path_d = time_to(lw, ay);
        a = face_coord(e.path_d, ax, lw, e.sx);
        b = face_coord(e.path_d, az, wz, e.sz);
      end else begin
        e.face = FACE_X;
        e.path_d = time_to(lw, ax);
        a = face_coord(e.path_d, ay, lw, e.sy);
        b = face_coord(e.path_d, az, wz, e.sz);
      end
      e.w0 = blend(65536 - a, 65536 - b, clamped);
      e.w1 = blend(a, 65536 - b, clamped);
      e.w2 = blend(a, b, clamped);
      e.w3 = blend(65536 - a, b, clamped);
      e.clamped = clamped;
      e.invalid = (lw == 0) || (zd == 0) || (zt == 0);
      pending.push_back(e);
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned got);
      if (exp_v != got) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, exp_v, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [1:0] u);
      face_hit_t e;
      if (pending.size() == 0) begin
        errors++;
        $error("result with no item pending: %h", d);
        return;
      end
      e = pending.pop_front();
      cmp("path_distance", e.path_d, d[31:0]);
      cmp("hit_face", e.face, u);
      cmp("sign_x", e.sx, d[32]);
      cmp("sign_y", e.sy, d[33]);
      cmp("sign_z", e.sz, d[34]);
      cmp("weight_0", e.w0, d[51:35]);
      cmp("weight_1", e.w1, d[68:52]);
      cmp("weight_2", e.w2, d[85:69]);
      cmp("weight_3", e.w3, d[102:86]);
      cmp("weight_clamped", e.clamped, d[103]);
      cmp("width_invalid", e.invalid, d[104]);
    endfunction
  endclass

  face_scoreboard sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      out_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold the item until the block takes it; drop valid only while idling
  task automatic send_ray(logic [15:0] th, logic [15:0] ch, logic [31:0] zd, logic [31:0] zt);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {zt, zd, ch, th};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_width(logic [31:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.half_w = v;
  endtask

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) == 0 ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0008_0000, 32'h0000_1000);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] q;
    q = 16'($urandom_range(3)) << 14;
    case ($urandom_range(4))
      0: return q;
      1: return q + 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_ray(rand_angle(), rand_angle(), rand_depth(), rand_depth());
  endtask

  initial begin
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h2000, 16'h1555, 16'hFFFF, 16'h6000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // straight down, straight up, axis-aligned horizontals, diagonals
    for (int i = 0; i < 8; i++) send_ray(angs[i], angs[(i * 3) % 8], 32'h0001_0000, 32'h0002_0000);
    send_ray(16'h2000, 16'h2000, 32'h0001_0000, 32'h0001_0000);
    send_ray(16'h4000, 16'h2000, 32'h0001_0000, 32'h0001_0000);
    send_ray(16'h1000, 16'h0000, 32'h0000_0000, 32'h0001_0000);
    send_ray(16'hC000, 16'h0000, 32'h0001_0000, 32'h0000_0000);
    send_ray(16'h0010, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ray(16'h3FF0, 16'h0100, 32'h0000_0001, 32'h0000_0001);
    send_ray(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_ray(16'h5555, 16'hAAAA, 32'h1234_5678, 32'h8765_4321);

    set_width(32'h0000_0001);
    send_ray(16'h4000, 16'h1000, 32'h0001_0000, 32'h0001_0000);
    send_ray(16'h2000, 16'h6000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_width(32'hFFFF_FFFF);
    send_ray(16'h4000, 16'h1000, 32'h0001_0000, 32'h0001_0000);
    send_ray(16'h0800, 16'h9000, 32'h0000_0001, 32'hFFFF_FFFF);
    set_width(32'h0000_0000);
    send_ray(16'h3000, 16'h1000, 32'h0001_0000, 32'h0001_0000);

    src_idle = 35;
    snk_idle = 55;
    set_width(32'h0001_0000);
    random_phase(300);
    set_width(32'h0000_8000);
    random_phase(150);
    // let the pipeline run dry, then resume
    drain();
    src_idle = 55;
    snk_idle = 35;
    set_width(32'h0010_0000);
    random_phase(250);
    set_width($urandom());
    random_phase(200);
    src_idle = 0;
    snk_idle = 0;
    set_width(32'h0000_4000);
    random_phase(300);
    set_width(32'hFFFF_FFFF);
    random_phase(100);
    set_width(32'h0000_0001);
    random_phase(130);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ ray_cell_face_intersection.f @@
hw/rtl/rcfi_pkg.sv
hw/rtl/rcfi_cordic.sv
hw/rtl/rcfi_udiv.sv
hw/rtl/ray_cell_face_intersection.sv
bench/tb_ray_cell_face_intersection.sv
